### src/atax_pkg.sv
// ----------------------------------------------------------------------------
// atax_pkg
// Shared widths, codes and types for the A^T (A x) kernel.
// ----------------------------------------------------------------------------
`default_nettype none

package atax_pkg;

  // Largest supported column count; storage depths follow from it
  localparam int MaxCols = 64;
  localparam int ColW    = $clog2(MaxCols);
  localparam int MaxRows = 4096;

  // Fixed field widths
  localparam int DataW   = 32;
  localparam int IdxW    = 6;
  localparam int ColsW   = 7;
  localparam int RowsW   = 13;
  localparam int RowCntW = 12;
  localparam int TdataW  = 40;

  // Configuration register indexes
  typedef enum logic {
    CfgCols = 1'b0,
    CfgRows = 1'b1
  } cfg_reg_e;

  // Input item kinds
  typedef enum logic {
    OpLoadX  = 1'b0,
    OpMatrix = 1'b1
  } opcode_e;

  // One finished row, handed from front to back
  typedef struct packed {
    logic [DataW-1:0] dot;
    logic [ColsW-1:0] nc;
    logic             bank;
    logic             first;
    logic             last_row;
  } row_desc_t;

  // Row buffer write from front into the back's banked memory
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [ColW-1:0]  addr;
    logic [DataW-1:0] data;
  } row_wr_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BkIdle,
    BkWalk,
    BkDrain,
    BkEmit,
    BkEmitTail
  } back_state_e;

endpackage

`default_nettype wire

### src/matrix_transpose_times_matrix_vector.sv
// ----------------------------------------------------------------------------
// matrix_transpose_times_matrix_vector
// Streaming y = A^T (A x) with 32-bit wrapping arithmetic.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake            Contents
//  cfg       in   cfg_we_i             cfg_idx_i: 0 cols, 1 rows; cfg_wdata_i
//  s_axis    in   tvalid/tready        tuser opcode; tdata index, value
//  m_axis    out  tvalid/tready/tlast  tdata y_index, y_value; tlast last
//
//  The front takes one item per cycle while tready is high. Per finished row
//  the back end pops a descriptor, walks one column per cycle through the y
//  memory port and drains the multiply-add; a two-bank row buffer lets the
//  front stream one row ahead, and tready drops while two rows wait. At run
//  end the cols results leave one per cycle, when m_axis_tready allows, via an
//  output register. No clearing pass after reset: y entries carry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_transpose_times_matrix_vector (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         cfg_we_i,
  input  wire                         cfg_idx_i,
  input  wire [atax_pkg::RowsW-1:0]   cfg_wdata_i,
  input  wire                         s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire [atax_pkg::TdataW-1:0]  s_axis_tdata_i,  // [5:0] index, [37:6] value
  input  wire                         s_axis_tuser_i,  // [0] opcode
  output logic                        m_axis_tvalid_o,
  input  wire                         m_axis_tready_i,
  output logic [atax_pkg::TdataW-1:0] m_axis_tdata_o,  // [5:0] y_index, [37:6] y_value
  output logic                        m_axis_tlast_o
);

  localparam int ValLo = atax_pkg::IdxW;
  localparam int ValHi = atax_pkg::IdxW + atax_pkg::DataW - 1;
  localparam int PadW  = atax_pkg::TdataW - atax_pkg::IdxW - atax_pkg::DataW;

  atax_pkg::row_wr_t            row_wr;
  logic                         push;
  atax_pkg::row_desc_t          push_desc;
  logic                         q_valid;
  atax_pkg::row_desc_t          q_desc;
  logic                         q_pop;
  logic                         row_done;
  logic [atax_pkg::IdxW-1:0]    m_index;
  logic [atax_pkg::DataW-1:0]   m_value;

  // Accept and classify items, build dot products
  atax_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_o   (s_axis_tready_o),
    .s_opcode_i  (s_axis_tuser_i),
    .s_index_i   (s_axis_tdata_i[atax_pkg::IdxW-1:0]),
    .s_value_i   (s_axis_tdata_i[ValHi:ValLo]),
    .row_wr_o    (row_wr),
    .push_o      (push),
    .push_desc_o (push_desc),
    .row_done_i  (row_done)
  );

  // Hold finished rows for the update walk
  atax_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .valid_o     (q_valid),
    .desc_o      (q_desc),
    .pop_i       (q_pop)
  );

  // Update y and emit results
  atax_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .row_wr_i   (row_wr),
    .q_valid_i  (q_valid),
    .q_desc_i   (q_desc),
    .q_pop_o    (q_pop),
    .row_done_o (row_done),
    .m_valid_o  (m_axis_tvalid_o),
    .m_ready_i  (m_axis_tready_i),
    .m_index_o  (m_index),
    .m_value_o  (m_value),
    .m_last_o   (m_axis_tlast_o)
  );

  // Pack the result fields
  assign m_axis_tdata_o = {{PadW{1'b0}}, m_value, m_index};

endmodule

`default_nettype wire

### src/atax_front.sv
// ----------------------------------------------------------------------------
// atax_front
// Accepts items, stores x, streams rows into the row buffer and forms the
// per-row dot product; posts one descriptor per finished row.
// ----------------------------------------------------------------------------
`default_nettype none

module atax_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire                              cfg_idx_i,
  input  wire [atax_pkg::RowsW-1:0]        cfg_wdata_i,
  input  wire                              s_valid_i,
  output logic                             s_ready_o,
  input  wire                              s_opcode_i,
  input  wire [atax_pkg::IdxW-1:0]         s_index_i,
  input  wire [atax_pkg::DataW-1:0]        s_value_i,
  output atax_pkg::row_wr_t                row_wr_o,
  output logic                             push_o,
  output atax_pkg::row_desc_t              push_desc_o,
  input  wire                              row_done_i
);

  logic [atax_pkg::ColsW-1:0]   cols_q;
  logic [atax_pkg::RowsW-1:0]   rows_q;
  logic [atax_pkg::ColsW-1:0]   nc;
  logic [atax_pkg::RowsW-1:0]   nr;
  logic [atax_pkg::ColW-1:0]    col_q;
  logic [atax_pkg::RowCntW-1:0] row_q;
  logic                         bank_q;
  logic [1:0]                   pending_q;
  logic                         accept;
  logic                         is_mat;
  logic                         mat_acc;
  logic                         idx_ok;
  logic                         row_end;
  logic                         run_end;

  logic [atax_pkg::DataW-1:0]   x_mem [atax_pkg::MaxCols];
  logic [atax_pkg::DataW-1:0]   x_rd_q;

  logic                         s1_v_q;
  logic                         s1_end_q;
  logic [atax_pkg::DataW-1:0]   s1_val_q;
  atax_pkg::row_desc_t          s1_desc_q;
  logic                         s2_v_q;
  logic                         s2_end_q;
  logic [atax_pkg::DataW-1:0]   prod_q;
  atax_pkg::row_desc_t          s2_desc_q;
  logic [atax_pkg::DataW-1:0]   dot_q;
  logic [atax_pkg::DataW-1:0]   dot_sum;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= atax_pkg::ColsW'(atax_pkg::MaxCols);
      rows_q <= atax_pkg::RowsW'(64);
    end else if (cfg_we_i) begin
      case (atax_pkg::cfg_reg_e'(cfg_idx_i))
        atax_pkg::CfgCols: cols_q <= cfg_wdata_i[atax_pkg::ColsW-1:0];
        atax_pkg::CfgRows: rows_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp sizes into their legal ranges
  always_comb begin
    if (cols_q == '0) begin
      nc = atax_pkg::ColsW'(1);
    end else if (cols_q > atax_pkg::ColsW'(atax_pkg::MaxCols)) begin
      nc = atax_pkg::ColsW'(atax_pkg::MaxCols);
    end else begin
      nc = cols_q;
    end
    if (rows_q == '0) begin
      nr = atax_pkg::RowsW'(1);
    end else if (rows_q > atax_pkg::RowsW'(atax_pkg::MaxRows)) begin
      nr = atax_pkg::RowsW'(atax_pkg::MaxRows);
    end else begin
      nr = rows_q;
    end
  end

  // Hold off while both row buffer banks still wait for the back end
  assign s_ready_o = (pending_q != 2'd2);
  assign accept    = s_valid_i && s_ready_o;
  assign is_mat    = (atax_pkg::opcode_e'(s_opcode_i) == atax_pkg::OpMatrix);
  assign mat_acc   = accept && is_mat;
  assign idx_ok    = ({1'b0, s_index_i} < (atax_pkg::IdxW + 1)'(atax_pkg::MaxCols));
  assign row_end   = ((atax_pkg::ColsW'(col_q) + atax_pkg::ColsW'(1)) >= nc);
  assign run_end   = row_end &&
                     ((atax_pkg::RowsW'(row_q) + atax_pkg::RowsW'(1)) >= nr);

  // x store: write on loads, read the current column on matrix items
  always_ff @(posedge clk_i) begin
    if (accept && !is_mat && idx_ok) begin
      x_mem[s_index_i[atax_pkg::ColW-1:0]] <= s_value_i;
    end
    if (mat_acc) begin
      x_rd_q <= x_mem[col_q];
    end
  end

  // Row element goes straight into the current bank
  always_comb begin
    row_wr_o.en   = mat_acc;
    row_wr_o.bank = bank_q;
    row_wr_o.addr = col_q;
    row_wr_o.data = s_value_i;
  end

  // Advance column, row and bank counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      bank_q <= 1'b0;
    end else if (mat_acc) begin
      if (row_end) begin
        col_q  <= '0;
        bank_q <= ~bank_q;
        if (run_end) begin
          row_q <= '0;
        end else begin
          row_q <= row_q + atax_pkg::RowCntW'(1);
        end
      end else begin
        col_q <= col_q + atax_pkg::ColW'(1);
      end
    end
  end

  // Count rows whose bank is not yet released by the back end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      case ({mat_acc && row_end, row_done_i})
        2'b10:   pending_q <= pending_q + 2'd1;
        2'b01:   pending_q <= pending_q - 2'd1;
        default: pending_q <= pending_q;
      endcase
    end
  end

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      dot_q  <= '0;
    end else begin
      s1_v_q <= mat_acc;
      s2_v_q <= s1_v_q;
      if (s2_v_q) begin
        dot_q <= s2_end_q ? '0 : dot_sum;
      end
    end
  end

  // Stage payload: capture item, then multiply by x
  always_ff @(posedge clk_i) begin
    if (mat_acc) begin
      s1_val_q           <= s_value_i;
      s1_end_q           <= row_end;
      s1_desc_q.dot      <= '0;
      s1_desc_q.nc       <= nc;
      s1_desc_q.bank     <= bank_q;
      s1_desc_q.first    <= (row_q == '0);
      s1_desc_q.last_row <= run_end;
    end
    if (s1_v_q) begin
      prod_q    <= s1_val_q * x_rd_q;
      s2_end_q  <= s1_end_q;
      s2_desc_q <= s1_desc_q;
    end
  end

  // Finish the dot product and post the row
  assign dot_sum = dot_q + prod_q;
  assign push_o  = s2_v_q && s2_end_q;

  always_comb begin
    push_desc_o     = s2_desc_q;
    push_desc_o.dot = dot_sum;
  end

endmodule

`default_nettype wire

### src/atax_queue.sv
// ----------------------------------------------------------------------------
// atax_queue
// Two-entry descriptor queue between the row front end and the update walk.
// ----------------------------------------------------------------------------
`default_nettype none

module atax_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  atax_pkg::row_desc_t  push_desc_i,
  output logic                 valid_o,
  output atax_pkg::row_desc_t  desc_o,
  input  wire                  pop_i
);

  atax_pkg::row_desc_t slot_q [2];
  logic                wr_ptr_q;
  logic                rd_ptr_q;
  logic [1:0]          count_q;

  assign valid_o = (count_q != 2'd0);
  assign desc_o  = slot_q[rd_ptr_q];

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_desc_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### src/atax_back.sv
// ----------------------------------------------------------------------------
// atax_back
// Walks each finished row, adds row[j] * dot into y, and emits y at run end.
// ----------------------------------------------------------------------------
`default_nettype none

module atax_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  atax_pkg::row_wr_t          row_wr_i,
  input  wire                        q_valid_i,
  input  atax_pkg::row_desc_t        q_desc_i,
  output logic                       q_pop_o,
  output logic                       row_done_o,
  output logic                       m_valid_o,
  input  wire                        m_ready_i,
  output logic [atax_pkg::IdxW-1:0]  m_index_o,
  output logic [atax_pkg::DataW-1:0] m_value_o,
  output logic                       m_last_o
);

  localparam int RowAddrW = atax_pkg::ColW + 1;

  atax_pkg::back_state_e       state_q;
  atax_pkg::back_state_e       state_d;
  atax_pkg::row_desc_t         desc_q;
  logic [atax_pkg::ColW-1:0]   j_q;
  logic [atax_pkg::ColW-1:0]   j_d;

  logic [atax_pkg::DataW-1:0]  row_mem [2 * atax_pkg::MaxCols];
  logic [atax_pkg::DataW-1:0]  y_mem   [atax_pkg::MaxCols];
  logic [atax_pkg::MaxCols-1:0] yv_q;

  logic                        at_last;
  logic                        walk_issue;
  logic                        e_issue;
  logic                        e_move;
  logic                        out_free;
  logic                        clear_y;

  logic [atax_pkg::DataW-1:0]  row_rd_q;
  logic [atax_pkg::DataW-1:0]  y_rd_q;
  logic                        y_rdv_q;
  logic                        p1_v_q;
  logic [atax_pkg::ColW-1:0]   p1_j_q;
  logic                        p2_v_q;
  logic [atax_pkg::ColW-1:0]   p2_j_q;
  logic [atax_pkg::DataW-1:0]  mprod_q;
  logic [atax_pkg::DataW-1:0]  yold_q;
  logic                        e_v_q;
  logic [atax_pkg::ColW-1:0]   e_j_q;

  logic                        m_valid_q;
  logic [atax_pkg::IdxW-1:0]   m_index_q;
  logic [atax_pkg::DataW-1:0]  m_value_q;
  logic                        m_last_q;

  assign at_last  = (atax_pkg::ColsW'(j_q) == desc_q.nc - atax_pkg::ColsW'(1));
  assign out_free = !m_valid_q || m_ready_i;
  assign e_move   = e_v_q && out_free;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      atax_pkg::BkIdle: begin
        if (q_valid_i) begin
          state_d = atax_pkg::BkWalk;
        end
      end
      atax_pkg::BkWalk: begin
        if (at_last) begin
          state_d = atax_pkg::BkDrain;
        end
      end
      atax_pkg::BkDrain: begin
        if (!p1_v_q && !p2_v_q) begin
          state_d = desc_q.last_row ? atax_pkg::BkEmit : atax_pkg::BkIdle;
        end
      end
      atax_pkg::BkEmit: begin
        if (e_issue && at_last) begin
          state_d = atax_pkg::BkEmitTail;
        end
      end
      atax_pkg::BkEmitTail: begin
        if (!e_v_q || e_move) begin
          state_d = atax_pkg::BkIdle;
        end
      end
      default: state_d = atax_pkg::BkIdle;
    endcase
  end

  // State outputs
  always_comb begin
    q_pop_o    = 1'b0;
    clear_y    = 1'b0;
    walk_issue = 1'b0;
    e_issue    = 1'b0;
    j_d        = j_q;
    case (state_q)
      atax_pkg::BkIdle: begin
        q_pop_o = q_valid_i;
        clear_y = q_valid_i && q_desc_i.first;
        j_d     = '0;
      end
      atax_pkg::BkWalk: begin
        walk_issue = 1'b1;
        j_d        = at_last ? '0 : j_q + atax_pkg::ColW'(1);
      end
      atax_pkg::BkEmit: begin
        e_issue = !e_v_q || e_move;
        if (e_issue) begin
          j_d = at_last ? '0 : j_q + atax_pkg::ColW'(1);
        end
      end
      default: j_d = j_q;
    endcase
  end

  assign row_done_o = walk_issue && at_last;

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= atax_pkg::BkIdle;
      j_q     <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
    end
  end

  // Latch the row being worked on
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      desc_q <= q_desc_i;
    end
  end

  // Row buffer: front writes one bank, the walk reads the other
  always_ff @(posedge clk_i) begin
    if (row_wr_i.en) begin
      row_mem[{row_wr_i.bank, row_wr_i.addr}] <= row_wr_i.data;
    end
    if (walk_issue) begin
      row_rd_q <= row_mem[RowAddrW'({desc_q.bank, j_q})];
    end
  end

  // y store: read for walk or emission, write the updated sum
  always_ff @(posedge clk_i) begin
    if (walk_issue || e_issue) begin
      y_rd_q <= y_mem[j_q];
    end
    if (p2_v_q) begin
      y_mem[p2_j_q] <= yold_q + mprod_q;
    end
  end

  // y valid bits: drop all at run start, mark on each write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yv_q    <= '0;
      y_rdv_q <= 1'b0;
    end else begin
      if (clear_y) begin
        yv_q <= '0;
      end else if (p2_v_q) begin
        yv_q[p2_j_q] <= 1'b1;
      end
      if (walk_issue || e_issue) begin
        y_rdv_q <= yv_q[j_q];
      end
    end
  end

  // Update pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else begin
      p1_v_q <= walk_issue;
      p2_v_q <= p1_v_q;
    end
  end

  // Update pipeline payload: multiply, then add on write
  always_ff @(posedge clk_i) begin
    if (walk_issue) begin
      p1_j_q <= j_q;
    end
    if (p1_v_q) begin
      p2_j_q  <= p1_j_q;
      mprod_q <= row_rd_q * desc_q.dot;
      yold_q  <= y_rdv_q ? y_rd_q : '0;
    end
  end

  // Emission read stage and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q     <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      if (e_issue) begin
        e_v_q <= 1'b1;
      end else if (e_move) begin
        e_v_q <= 1'b0;
      end
      if (e_move) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (e_issue) begin
      e_j_q <= j_q;
    end
    if (e_move) begin
      m_index_q <= atax_pkg::IdxW'(e_j_q);
      m_value_q <= y_rdv_q ? y_rd_q : '0;
      m_last_q  <= (atax_pkg::ColsW'(e_j_q) == desc_q.nc - atax_pkg::ColsW'(1));
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_index_o = m_index_q;
  assign m_value_o = m_value_q;
  assign m_last_o  = m_last_q;

endmodule

`default_nettype wire

### verif/atax_check_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// atax_check_pkg
// Result tracker for the A^T (A x) kernel testbench: it follows every accepted
// item, works out the y elements each finished run must produce and compares
// them, field by field and in order, with the items leaving the block.
// ----------------------------------------------------------------------------

package atax_check_pkg;

  import atax_pkg::*;

  // One expected output item
  typedef struct {
    logic [IdxW-1:0]  idx;
    logic [DataW-1:0] value;
    logic             last;
  } y_elem_t;

  class yvec_tracker;

    localparam int MaxReports = 40;

    // Register copies
    logic [ColsW-1:0] cols_reg;
    logic [RowsW-1:0] rows_reg;

    // Kernel state
    logic [DataW-1:0] x_mem   [MaxCols];
    bit               x_loaded[MaxCols];
    logic [DataW-1:0] row_mem [MaxCols];
    logic [DataW-1:0] y_acc   [MaxCols];
    logic [DataW-1:0] dot;
    int unsigned      col_cnt;
    int unsigned      row_cnt;

    // y elements still to arrive, oldest first
    y_elem_t     pending_y[$];
    int unsigned runs_done;
    int unsigned y_checked;
    int unsigned errors;

    function new();
      cols_reg = ColsW'(MaxCols);
      rows_reg = RowsW'(64);
      for (int j = 0; j < MaxCols; j++) begin
        x_mem[j]    = '0;
        x_loaded[j] = 1'b0;
        row_mem[j]  = '0;
        y_acc[j]    = '0;
      end
      dot       = '0;
      col_cnt   = 0;
      row_cnt   = 0;
      runs_done = 0;
      y_checked = 0;
      errors    = 0;
    endfunction

    // Zero acts as one, large values clip to the storage limits
    function int unsigned col_limit();
      int unsigned c;
      c = cols_reg;
      if (c == 0) c = 1;
      if (c > MaxCols) c = MaxCols;
      return c;
    endfunction

    function int unsigned row_limit();
      int unsigned r;
      r = rows_reg;
      if (r == 0) r = 1;
      if (r > MaxRows) r = MaxRows;
      return r;
    endfunction

    function void write_reg(cfg_reg_e which, logic [RowsW-1:0] data);
      case (which)
        CfgCols: cols_reg = data[ColsW-1:0];
        CfgRows: rows_reg = data;
        default: ;
      endcase
    endfunction

    // Advance the kernel by one accepted item and queue any y elements it yields
    function void take_item(opcode_e op, logic [IdxW-1:0] idx, logic [DataW-1:0] value);
      int unsigned nc;
      int unsigned nr;
      y_elem_t     y;
      if (op == OpLoadX) begin
        x_mem[idx]    = value;
        x_loaded[idx] = 1'b1;
        return;
      end
      nc = col_limit();
      nr = row_limit();
      // first matrix element of a run starts y from zero
      if (col_cnt == 0 && row_cnt == 0) begin
        for (int j = 0; j < MaxCols; j++) y_acc[j] = '0;
      end
      row_mem[col_cnt] = value;
      dot = dot + value * x_mem[col_cnt];
      // a row (or run) closes once its counter reaches or has passed the limit
      if (col_cnt + 1 >= nc) begin
        for (int j = 0; j < nc; j++) y_acc[j] = y_acc[j] + row_mem[j] * dot;
        dot     = '0;
        col_cnt = 0;
        if (row_cnt + 1 >= nr) begin
          row_cnt = 0;
          for (int j = 0; j < nc; j++) begin
            y.idx   = IdxW'(j);
            y.value = y_acc[j];
            y.last  = (j + 1 == nc);
            pending_y.push_back(y);
          end
          runs_done++;
        end else begin
          row_cnt = (row_cnt + 1) & ((1 << RowCntW) - 1);
        end
      end else begin
        col_cnt = (col_cnt + 1) & (MaxCols - 1);
      end
    endfunction

    function void report_field(string what, logic [DataW-1:0] want, logic [DataW-1:0] got);
      errors++;
      if (errors <= MaxReports) begin
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
      end else if (errors == MaxReports + 1) begin
        $display("%0t: further mismatches are counted but not shown", $time);
      end
    endfunction

    // Compare one output item with the oldest expected y element
    function void check_y(logic [IdxW-1:0] idx, logic [DataW-1:0] value, logic last);
      y_elem_t want;
      if (pending_y.size() == 0) begin
        errors++;
        $display("%0t: unexpected y item: expected none, got index %0d value %0h last %0b",
                 $time, idx, value, last);
        return;
      end
      want = pending_y.pop_front();
      y_checked++;
      if (idx !== want.idx) report_field("y_index", want.idx, idx);
      if (value !== want.value) report_field("y_value", want.value, value);
      if (last !== want.last) report_field("last", want.last, last);
    endfunction

  endclass

endpackage

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the A^T (A x) kernel. Loads x, streams matrix rows
// under many column and row settings (zero, clipped and mid-run changes among
// them) with random gaps and stalls on both streams, and checks every y item
// against a tracker that follows the kernel item by item.
// ----------------------------------------------------------------------------

module testbench;

  import atax_pkg::*;
  import atax_check_pkg::*;

  localparam int HalfPeriod   = 4;
  localparam int ResetCycles  = 8;
  localparam int SettleCycles = 200;
  localparam int HoldCycles   = 400;
  localparam int StallLimit   = 4000;
  localparam int RandomItems  = 60;
  localparam int PadW         = TdataW - IdxW - DataW;

  // Clock, reset and stimulus registers
  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              cfg_we    = 1'b0;
  cfg_reg_e          cfg_idx   = CfgCols;
  logic [RowsW-1:0]  cfg_wdata = '0;
  logic              s_valid   = 1'b0;
  logic [TdataW-1:0] s_tdata   = '0;
  opcode_e           s_op      = OpLoadX;
  logic              m_ready   = 1'b0;

  // Idling control
  logic              steady    = 1'b0;
  int unsigned       hold_reqs = 0;
  int unsigned       hold_seen = 0;
  int unsigned       hold_left = 0;

  wire               s_tready;
  wire               m_valid;
  wire [TdataW-1:0]  m_tdata;
  wire               m_tlast;

  yvec_tracker       yvec = new();
  int unsigned       item_count = 0;

  always #(HalfPeriod) clk_i = ~clk_i;

  matrix_transpose_times_matrix_vector dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_op),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  // Check each y item and pick the next ready; serve hold-off requests
  always @(posedge clk_i) begin
    if (rst_ni && m_valid && m_ready) begin
      yvec.check_y(m_tdata[IdxW-1:0], m_tdata[IdxW+DataW-1:IdxW], m_tlast);
    end
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
      m_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= steady || ($urandom_range(99) >= 15);
    end
  end

  // End the run when no item moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_tready) || (m_valid && m_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no item moved for %0d cycles", $time, StallLimit);
    $display("FAILURE");
    $finish;
  end

  function automatic logic [DataW-1:0] pick_value();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return '1;
      4:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input cfg_reg_e which, input logic [RowsW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= which;
    cfg_wdata <= data;
    @(posedge clk_i);
    yvec.write_reg(which, data);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one item, with an occasional gap first, and hold it until taken
  task automatic send_item(input opcode_e op, input logic [IdxW-1:0] idx,
                           input logic [DataW-1:0] value);
    if (!steady && $urandom_range(99) < 15) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_op    <= op;
    s_tdata <= {{PadW{1'b0}}, value, idx};
    do @(posedge clk_i); while (!s_tready);
    yvec.take_item(op, idx, value);
    item_count++;
  endtask

  task automatic send_element(input logic [DataW-1:0] value);
    send_item(OpMatrix, IdxW'($urandom_range(63)), value);
  endtask

  // Drop valid, wait for every expected y item, then let the block go quiet
  task automatic settle();
    s_valid <= 1'b0;
    while (yvec.pending_y.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Load every x entry the current column count can read and that is still unset
  task automatic fill_x();
    int unsigned lim;
    int unsigned base;
    int unsigned j;
    lim  = yvec.col_limit();
    base = $urandom_range(lim - 1);
    for (int k = 0; k < lim; k++) begin
      j = (base + k) % lim;
      if (!yvec.x_loaded[j]) send_item(OpLoadX, IdxW'(j), $urandom);
    end
  endtask

  // Stream matrix elements until the given number of runs has closed
  task automatic stream_runs(input int unsigned runs, input bit noisy);
    int unsigned target;
    target = yvec.runs_done + runs;
    while (yvec.runs_done < target) begin
      if (noisy && $urandom_range(99) < 10) begin
        send_item(OpLoadX, IdxW'($urandom_range(63)), pick_value());
      end else begin
        send_element(pick_value());
      end
    end
  endtask

  initial begin : stimulus
    int unsigned      random_start;
    int unsigned      phase;
    int unsigned      cfg_writes;
    logic [ColsW-1:0] cols_val;
    logic [RowsW-1:0] rows_val;

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Two rows of three: extreme x and matrix values, both index extremes
    write_reg(CfgCols, 3);
    write_reg(CfgRows, 2);
    send_item(OpLoadX, 0, 32'h7FFF_FFFF);
    send_item(OpLoadX, 1, 32'h8000_0000);
    send_item(OpLoadX, 2, 32'hFFFF_FFFF);
    send_item(OpLoadX, 63, 32'h0000_0001);
    send_item(OpMatrix, 63, 32'h7FFF_FFFF);
    send_item(OpMatrix, 0, 32'h8000_0000);
    send_item(OpMatrix, 21, 32'hFFFF_FFFF);
    send_item(OpMatrix, 42, 32'h0000_0000);
    send_item(OpMatrix, 0, 32'h0000_0001);
    send_item(OpMatrix, 63, 32'h8000_0000);
    settle();

    // Zero sizes act as one: every element is a whole run
    write_reg(CfgCols, 0);
    write_reg(CfgRows, 0);
    send_element(32'h8000_0000);
    send_element(32'h7FFF_FFFF);
    send_element(32'h0000_0000);
    settle();

    // Shrink both sizes in the middle of a row of the second row
    write_reg(CfgCols, 4);
    write_reg(CfgRows, 3);
    send_item(OpLoadX, 3, 32'h0001_0003);
    repeat (5) send_element(pick_value());
    settle();
    write_reg(CfgCols, 2);
    write_reg(CfgRows, 1);
    send_element(pick_value());
    settle();

    // Grow the column count in the middle of a row
    write_reg(CfgRows, 2);
    send_element(pick_value());
    settle();
    write_reg(CfgCols, 4);
    repeat (7) send_element(pick_value());
    settle();

    // Column count above the limit clips to the widest row; no idling here
    steady <= 1'b1;
    write_reg(CfgCols, 127);
    write_reg(CfgRows, 1);
    fill_x();
    stream_runs(1, 1'b0);
    settle();
    steady <= 1'b0;

    // Receiver holds off while short runs keep coming, so the block backs up
    write_reg(CfgCols, 2);
    write_reg(CfgRows, 1);
    hold_reqs <= hold_reqs + 1;
    stream_runs(12, 1'b0);
    settle();

    // Random phases: new sizes, missing x, a few runs, sometimes a run left open
    random_start = item_count;
    phase        = 0;
    cfg_writes   = 0;
    while (item_count - random_start < RandomItems) begin
      case ($urandom_range(19))
        0:       cols_val = 0;
        1:       cols_val = ColsW'($urandom_range(9, 16));
        default: cols_val = ColsW'($urandom_range(1, 8));
      endcase
      case ($urandom_range(19))
        0:       rows_val = 0;
        1:       rows_val = RowsW'($urandom_range(5, 8));
        default: rows_val = RowsW'($urandom_range(1, 4));
      endcase
      if ($urandom_range(1)) begin
        write_reg(CfgCols, RowsW'(cols_val));
        write_reg(CfgRows, rows_val);
      end else begin
        write_reg(CfgRows, rows_val);
        write_reg(CfgCols, RowsW'(cols_val));
      end
      cfg_writes += 2;
      steady <= (phase == 2);
      fill_x();
      stream_runs($urandom_range(1, 2), 1'b1);
      if ($urandom_range(99) < 20) begin
        repeat ($urandom_range(1, 5)) send_element(pick_value());
      end
      settle();
      phase++;
    end
    steady <= 1'b0;

    $display("Ran %0d input items in %0d runs, %0d random phases with %0d size writes;",
             item_count, yvec.runs_done, phase, cfg_writes);
    $display("checked %0d y items, %0d mismatches", yvec.y_checked, yvec.errors);
    if (yvec.errors == 0 && yvec.pending_y.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
src/atax_pkg.sv
src/atax_front.sv
src/atax_queue.sv
src/atax_back.sv
src/matrix_transpose_times_matrix_vector.sv
verif/atax_check_pkg.sv
verif/testbench.sv
